// File: src/mm3_pkg.sv
// Shared constants and types for the MurmurHash3 x86_32 engine.
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] MUL_A = 32'hcc9e2d51;
  localparam logic [31:0] MUL_B = 32'h1b873593;
  localparam int unsigned ROT_K = 15;
  localparam int unsigned ROT_H = 13;
  localparam logic [31:0] ADD_H = 32'he6546b64;
  localparam logic [31:0] FIN_A = 32'h85ebca6b;
  localparam logic [31:0] FIN_B = 32'hc2b2ae35;

  localparam logic [2:0] CNT_FULL = 3'd4;

  // One scrambled word as it travels from front to back.
  typedef struct packed {
    logic [31:0] k;     // scrambled (masked) word
    logic [2:0]  cnt;   // effective byte count, 0..4
    logic        last;
  } q_entry_t;

  // Back-end sequencer, one-hot.
  typedef enum logic [4:0] {
    ST_RUN  = 5'b00001,
    ST_FIN0 = 5'b00010,
    ST_FIN1 = 5'b00100,
    ST_FIN2 = 5'b01000,
    ST_FIN3 = 5'b10000
  } back_state_t;

endpackage

// File: src/mm3_queue.sv
// Small FIFO between the scramble front end and the hash back end.
`timescale 1ns / 1ps

module mm3_queue #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  mm3_pkg::q_entry_t          push_entry,
  input  logic                       pop,
  output mm3_pkg::q_entry_t          head,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mm3_pkg::q_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);

endmodule

// File: src/mm3_front.sv
// Front end: accepts words, masks the tail and scrambles in a 3-stage pipe.
`timescale 1ns / 1ps

module mm3_front #(
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [31:0]                data_word,
  input  logic [2:0]                 byte_count,
  input  logic                       last,
  input  logic [$clog2(DEPTH+1)-1:0] q_count,
  output logic                       q_push,
  output mm3_pkg::q_entry_t          q_entry
);

  localparam int CW = $clog2(DEPTH + 1);

  logic        va, vb, vc;
  logic [31:0] wa, kb;
  logic [2:0]  ca, cb;
  logic        la, lb;
  mm3_pkg::q_entry_t ec;

  logic [2:0]  cnt_eff;
  logic [31:0] word_m;
  logic [31:0] kb_rot;
  logic [CW:0] used;
  logic        take;

  // Credit check: everything in the pipe plus the queue fits in the queue.
  assign used = (CW+1)'(va) + (CW+1)'(vb) + (CW+1)'(vc) + (CW+1)'(q_count);
  assign in_stall = (used >= (CW+1)'(DEPTH));
  assign take = in_valid && !in_stall;

  always_comb begin
    cnt_eff = (!last || byte_count > mm3_pkg::CNT_FULL) ? mm3_pkg::CNT_FULL : byte_count;
    case (cnt_eff)
      3'd0:    word_m = 32'd0;
      3'd1:    word_m = {24'd0, data_word[7:0]};
      3'd2:    word_m = {16'd0, data_word[15:0]};
      3'd3:    word_m = {8'd0, data_word[23:0]};
      default: word_m = data_word;
    endcase
  end

  assign kb_rot = {kb[31-mm3_pkg::ROT_K:0], kb[31:32-mm3_pkg::ROT_K]};

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= take;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    wa   <= word_m;
    ca   <= cnt_eff;
    la   <= last;
    kb   <= wa * mm3_pkg::MUL_A;
    cb   <= ca;
    lb   <= la;
    ec.k    <= kb_rot * mm3_pkg::MUL_B;
    ec.cnt  <= cb;
    ec.last <= lb;
  end

  assign q_push  = vc;
  assign q_entry = ec;

endmodule

// File: src/mm3_back.sv
// Back end: running hash update, length fold, final avalanche, result register.
`timescale 1ns / 1ps

module mm3_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       seed,
  input  mm3_pkg::q_entry_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       hash_value
);

  mm3_pkg::back_state_t state, state_next;

  logic [31:0] running_hash;
  logic [31:0] byte_total;
  logic        in_message;
  logic [31:0] acc;

  logic [31:0] h0, bt0, hx, hr, h_new, bt_new, fold, x13;
  logic        out_free;

  assign q_pop    = (state == mm3_pkg::ST_RUN) && !q_empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    h0     = in_message ? running_hash : seed;
    bt0    = in_message ? byte_total : 32'd0;
    hx     = h0 ^ head.k;
    hr     = {hx[31-mm3_pkg::ROT_H:0], hx[31:32-mm3_pkg::ROT_H]};
    h_new  = (head.cnt == mm3_pkg::CNT_FULL) ? ((hr << 2) + hr + mm3_pkg::ADD_H) : hx;
    bt_new = bt0 + 32'(head.cnt);
    fold   = acc ^ byte_total;
    x13    = acc ^ (acc >> 13);
  end

  always_comb begin
    state_next = state;
    case (state)
      mm3_pkg::ST_RUN:  if (q_pop && head.last) state_next = mm3_pkg::ST_FIN0;
      mm3_pkg::ST_FIN0: state_next = mm3_pkg::ST_FIN1;
      mm3_pkg::ST_FIN1: state_next = mm3_pkg::ST_FIN2;
      mm3_pkg::ST_FIN2: state_next = mm3_pkg::ST_FIN3;
      mm3_pkg::ST_FIN3: if (out_free) state_next = mm3_pkg::ST_RUN;
      default:          state_next = mm3_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mm3_pkg::ST_RUN;
      in_message <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        in_message <= !head.last;
      end
      if (state == mm3_pkg::ST_FIN3 && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      running_hash <= h_new;
      byte_total   <= bt_new;
      acc          <= h_new;
    end
    case (state)
      mm3_pkg::ST_FIN0: acc <= fold ^ (fold >> 16);
      mm3_pkg::ST_FIN1: acc <= acc * mm3_pkg::FIN_A;
      mm3_pkg::ST_FIN2: acc <= x13 * mm3_pkg::FIN_B;
      default: ;
    endcase
    if (state == mm3_pkg::ST_FIN3 && out_free) begin
      hash_value <= acc ^ (acc >> 16);
    end
  end

endmodule

// File: src/murmur3_hash32_engine.sv
// Top level of the seeded MurmurHash3 x86_32 engine.
`timescale 1ns / 1ps
//
//  channel | direction | signals                                  | transfer when
//  --------+-----------+------------------------------------------+-------------------------
//  input   | in        | in_valid/in_stall, data_word,            | in_valid && !in_stall
//          |           | byte_count, last                         |
//  result  | out       | out_valid/out_stall, hash_value          | out_valid && !out_stall
//  seed    | in        | seed_we, seed_wdata                      | seed_we
//
//  Words that are not last sustain one transfer per cycle: the front scrambles in a
//  3-stage multiplier pipe, the back does the rotate/x5/add update as it pops each word.
//  A last word holds the back through ST_FIN0..ST_FIN3 (length fold, two avalanche multiplies,
//  result load); input keeps flowing into the queue meanwhile until its credits run out.
//  With no stalls, out_valid rises once the last word clears the front pipe, queue and FIN states.
//  rst is synchronous and active high; it empties the pipe and queue and clears seed.
//  A stalled result holds in the output register while the back keeps absorbing words.

module murmur3_hash32_engine #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [31:0]       seed;
  logic              q_push, q_pop, q_empty;
  logic [CW-1:0]     q_count;
  mm3_pkg::q_entry_t q_in, q_head;

  // Seed is sampled by the back end at the first word of each message.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (seed_we) begin
      seed <= seed_wdata;
    end
  end

  mm3_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  mm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .count      (q_count)
  );

  mm3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |-> (q_count < CW'(QUEUE_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_count != '0))
    else $error("pop from empty queue");
`endif

endmodule
